// ----- src/assert_macros.svh -----
// shared assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bmr_pkg.sv -----
`default_nettype none
package bmr_pkg;

	// data and count widths
	localparam int W          = 31;
	localparam int CW         = 7;
	localparam int MAX_TERMS  = 64;
	localparam int POLY_DEPTH = MAX_TERMS + 1;
	localparam int TAW        = $clog2(MAX_TERMS);
	localparam int PAW        = $clog2(POLY_DEPTH);
	localparam int SW         = $clog2(W);

	localparam logic [W-1:0] RESET_MODULUS = 31'd1000000007;

	// input item
	typedef struct packed {
		logic [W-1:0] term_value;
		logic         last_term;
	} bmr_in_t;

	// result item
	typedef struct packed {
		logic [W-1:0]  coefficient;
		logic [CW-1:0] coef_index;
		logic [CW-1:0] rec_length;
		logic          run_end;
	} bmr_out_t;

	// request to the shared modular multiplier
	typedef struct packed {
		logic         start;
		logic [W-1:0] a;
		logic [W-1:0] b;
	} mm_req_t;

	// answer of the shared modular multiplier
	typedef struct packed {
		logic         done;
		logic [W-1:0] value;
	} mm_rsp_t;

endpackage
`default_nettype wire

// ----- src/bmr_ram.sv -----
`default_nettype none
module bmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- src/bmr_mulmod.sv -----
`default_nettype none
module bmr_mulmod import bmr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  mm_req_t      req,
	input  logic [W-1:0] pmod,
	output mm_rsp_t      rsp
);

	logic          busy_q;
	logic          red_q;
	logic          done_q;
	logic [SW-1:0] cnt_q;
	logic [W-1:0]  sh_q;
	logic [W-1:0]  yv_q;
	logic [W-1:0]  xh_q;
	logic [W-1:0]  acc_q;
	logic [W+1:0]  t;
	logic [W+1:0]  p1;
	logic [W+1:0]  p2;
	logic [W-1:0]  acc_nxt;

	// one bit of a msb-first interleaved multiply, acc stays below p
	always_comb begin
		p1 = {2'b00, pmod};
		p2 = {1'b0, pmod, 1'b0};
		t  = {1'b0, acc_q, 1'b0} + {2'b00, (sh_q[W-1] ? yv_q : {W{1'b0}})};
		if (t >= p2) begin
			acc_nxt = W'(t - p2);
		end else if (t >= p1) begin
			acc_nxt = W'(t - p1);
		end else begin
			acc_nxt = t[W-1:0];
		end
	end

	// b is first reduced as b*1 when it is not below p
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			red_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
			yv_q   <= '0;
			xh_q   <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					acc_q <= '0;
					cnt_q <= SW'(W - 1);
					if (req.a == '0) begin
						done_q <= 1'b1;
					end else if (req.b >= pmod) begin
						busy_q <= 1'b1;
						red_q  <= 1'b1;
						sh_q   <= req.b;
						yv_q   <= W'(1);
						xh_q   <= req.a;
					end else begin
						busy_q <= 1'b1;
						red_q  <= 1'b0;
						sh_q   <= req.a;
						yv_q   <= req.b;
					end
				end
			end else begin
				acc_q <= acc_nxt;
				sh_q  <= sh_q << 1;
				cnt_q <= cnt_q - SW'(1);
				if (cnt_q == '0) begin
					if (red_q) begin
						red_q <= 1'b0;
						yv_q  <= acc_nxt;
						sh_q  <= xh_q;
						acc_q <= '0;
						cnt_q <= SW'(W - 1);
					end else begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = acc_q;

endmodule
`default_nettype wire

// ----- src/berlekamp_massey_recurrence_unit.sv -----
// Berlekamp-Massey recurrence finder over a prime field.
// Input channel in_valid/in_stall/in_data carries one sequence term per
// transfer, with last_term marking the end of a sequence. After the last term
// the block sends the L coefficients c_1..c_L on out_valid/out_stall/out_data,
// one transfer each, run_end set on the final one; L of zero gives a single
// all-zero item with run_end set. cfg_we/cfg_wdata write the modulus.
// All multiplications and reductions run on one bit-serial modular multiplier;
// a product is quicker when the first operand is zero and needs an extra
// reduction pass when the second one is not below the modulus. Each term
// takes one product per connection coefficient for its discrepancy and, when
// the discrepancy is nonzero, up to 63 products for the inverse plus a
// polynomial update over all 65 entries. The run reduces each coefficient once.
// in_stall stays high while a term or a run is in progress.
// Reset sets the modulus to 1000000007 and empties the sequence. A result
// held under out_stall stays in the output register while the block clears
// and takes the next term.
`default_nettype none
module berlekamp_massey_recurrence_unit import bmr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [W-1:0] cfg_wdata,
	input  logic         in_valid,
	output logic         in_stall,
	input  bmr_in_t      in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output bmr_out_t     out_data
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_RIN_W   = 5'd1;
	localparam logic [4:0] ST_DSC_RD  = 5'd2;
	localparam logic [4:0] ST_DSC_DAT = 5'd3;
	localparam logic [4:0] ST_DSC_W   = 5'd4;
	localparam logic [4:0] ST_CHK     = 5'd5;
	localparam logic [4:0] ST_INV_RB  = 5'd6;
	localparam logic [4:0] ST_INV_SQ  = 5'd7;
	localparam logic [4:0] ST_INV_SQW = 5'd8;
	localparam logic [4:0] ST_INV_MUW = 5'd9;
	localparam logic [4:0] ST_FAC     = 5'd10;
	localparam logic [4:0] ST_FAC_W   = 5'd11;
	localparam logic [4:0] ST_UPD_RD  = 5'd12;
	localparam logic [4:0] ST_UPD_DAT = 5'd13;
	localparam logic [4:0] ST_UPD_M1  = 5'd14;
	localparam logic [4:0] ST_UPD_RC  = 5'd15;
	localparam logic [4:0] ST_UPD_M2  = 5'd16;
	localparam logic [4:0] ST_UPD_WR  = 5'd17;
	localparam logic [4:0] ST_UPD_NX  = 5'd18;
	localparam logic [4:0] ST_UPD_END = 5'd19;
	localparam logic [4:0] ST_FIN     = 5'd20;
	localparam logic [4:0] ST_EM_ST   = 5'd21;
	localparam logic [4:0] ST_EM_RD   = 5'd22;
	localparam logic [4:0] ST_EM_DAT  = 5'd23;
	localparam logic [4:0] ST_EM_W    = 5'd24;
	localparam logic [4:0] ST_EM_OUT  = 5'd25;
	localparam logic [4:0] ST_CLR     = 5'd26;

	logic [4:0]          state_q;
	logic [W-1:0]        mod_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       len_q;
	logic [CW-1:0]       shift_q;
	logic [W-1:0]        ldisc_q;
	logic                last_q;
	logic                chg_q;
	logic [PAW-1:0]      i_q;
	logic [PAW-1:0]      k_q;
	logic [PAW-1:0]      pos_q;
	logic [SW-1:0]       j_q;
	logic [W-1:0]        d_q;
	logic [W-1:0]        base_q;
	logic [W-1:0]        inv_q;
	logic [W-1:0]        f_q;
	logic [W-1:0]        cold_q;
	logic [W-1:0]        sub_q;
	logic [W-1:0]        cr_q;
	logic [W-1:0]        coef_q;
	logic [POLY_DEPTH-1:0] cvld_q;
	logic [POLY_DEPTH-1:0] pvld_q;
	logic                cv_s1;
	logic                cz_s1;
	logic                pv_s1;
	logic                pz_s1;
	logic                ovld_q;
	bmr_out_t            out_q;

	logic [W-1:0]        pe;
	logic [W-1:0]        expo;
	logic                in_xfer;
	logic                out_load;
	mm_req_t             mm_req;
	mm_rsp_t             mm_rsp;
	logic [PAW-1:0]      cra;
	logic [PAW-1:0]      pra;
	logic [TAW-1:0]      tra;
	logic [W-1:0]        c_rd;
	logic [W-1:0]        p_rd;
	logic [W-1:0]        t_rd;
	logic [W-1:0]        cval;
	logic [W-1:0]        pval;
	logic                c_we;
	logic                p_we;
	logic [W-1:0]        p_wd;
	logic                t_we;
	logic [W-1:0]        diff;
	logic [W:0]          dsum;
	logic [W-1:0]        d_nxt;
	logic [CW-1:0]       lim;

	// effective modulus and fermat exponent
	assign pe   = (mod_q < W'(2)) ? W'(2) : mod_q;
	assign expo = pe - W'(2);

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_load = !ovld_q && (state_q == ST_EM_OUT
		|| (state_q == ST_EM_ST && len_q == '0));

	// read addresses and entry values, unwritten entries read as reset value
	assign cra  = (state_q == ST_DSC_RD) ? i_q : (state_q == ST_EM_RD) ? k_q : pos_q;
	assign pra  = pos_q - shift_q;
	assign tra  = TAW'(n_q - CW'(i_q));
	assign cval = cv_s1 ? c_rd : {{(W-1){1'b0}}, cz_s1};
	assign pval = pv_s1 ? p_rd : {{(W-1){1'b0}}, pz_s1};

	// arithmetic around the multiplier
	assign diff  = cr_q - sub_q + ((cr_q < sub_q) ? pe : '0);
	assign dsum  = {1'b0, d_q} + {1'b0, mm_rsp.value};
	assign d_nxt = (dsum >= {1'b0, pe}) ? W'(dsum - {1'b0, pe}) : dsum[W-1:0];
	assign lim   = (len_q < n_q) ? len_q : n_q;

	// memory writes
	assign t_we = (state_q == ST_RIN_W) && mm_rsp.done;
	assign c_we = (state_q == ST_UPD_WR);
	assign p_we = chg_q && ((state_q == ST_UPD_WR)
		|| (state_q == ST_UPD_DAT && pos_q < PAW'(shift_q)));
	assign p_wd = (state_q == ST_UPD_WR) ? cold_q : cval;

	// multiplier requests
	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = '0;
		mm_req.b     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && cnt_q < CW'(MAX_TERMS)) begin
					mm_req.start = 1'b1;
					mm_req.a     = in_data.term_value;
					mm_req.b     = W'(1);
				end
			end
			ST_DSC_DAT: begin
				mm_req.start = 1'b1;
				mm_req.a     = cval;
				mm_req.b     = t_rd;
			end
			ST_CHK: begin
				mm_req.start = (d_q != '0);
				mm_req.a     = ldisc_q;
				mm_req.b     = W'(1);
			end
			ST_INV_SQ: begin
				mm_req.start = 1'b1;
				mm_req.a     = inv_q;
				mm_req.b     = inv_q;
			end
			ST_INV_SQW: begin
				mm_req.start = mm_rsp.done && expo[j_q];
				mm_req.a     = mm_rsp.value;
				mm_req.b     = base_q;
			end
			ST_FAC: begin
				mm_req.start = 1'b1;
				mm_req.a     = d_q;
				mm_req.b     = inv_q;
			end
			ST_UPD_DAT: begin
				mm_req.start = (pos_q >= PAW'(shift_q));
				mm_req.a     = pval;
				mm_req.b     = f_q;
			end
			ST_UPD_RC: begin
				mm_req.start = (cold_q >= pe);
				mm_req.a     = cold_q;
				mm_req.b     = W'(1);
			end
			ST_EM_DAT: begin
				mm_req.start = 1'b1;
				mm_req.a     = cval;
				mm_req.b     = W'(1);
			end
			default: begin
				mm_req.start = 1'b0;
			end
		endcase
	end

	bmr_mulmod u_mm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.pmod   (pe),
		.rsp    (mm_rsp)
	);

	bmr_ram #(.WIDTH(W), .DEPTH(MAX_TERMS)) u_term (
		.clk   (clk),
		.we    (t_we),
		.waddr (cnt_q[TAW-1:0]),
		.wdata (mm_rsp.value),
		.raddr (tra),
		.rdata (t_rd)
	);

	bmr_ram #(.WIDTH(W), .DEPTH(POLY_DEPTH)) u_conn (
		.clk   (clk),
		.we    (c_we),
		.waddr (pos_q),
		.wdata (diff),
		.raddr (cra),
		.rdata (c_rd)
	);

	bmr_ram #(.WIDTH(W), .DEPTH(POLY_DEPTH)) u_prev (
		.clk   (clk),
		.we    (p_we),
		.waddr (pos_q),
		.wdata (p_wd),
		.raddr (pra),
		.rdata (p_rd)
	);

	// valid bits follow the registered reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s1 <= 1'b0;
			cz_s1 <= 1'b0;
			pv_s1 <= 1'b0;
			pz_s1 <= 1'b0;
		end else begin
			cv_s1 <= (cra < PAW'(POLY_DEPTH)) ? cvld_q[cra] : 1'b0;
			cz_s1 <= (cra == '0);
			pv_s1 <= (pra < PAW'(POLY_DEPTH)) ? pvld_q[pra] : 1'b0;
			pz_s1 <= (pra == '0);
		end
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= RESET_MODULUS;
		end else if (cfg_we) begin
			mod_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
			len_q   <= '0;
			shift_q <= CW'(1);
			ldisc_q <= W'(1);
			last_q  <= 1'b0;
			chg_q   <= 1'b0;
			i_q     <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			j_q     <= '0;
			d_q     <= '0;
			base_q  <= '0;
			inv_q   <= '0;
			f_q     <= '0;
			cold_q  <= '0;
			sub_q   <= '0;
			cr_q    <= '0;
			coef_q  <= '0;
			cvld_q  <= '0;
			pvld_q  <= '0;
		end else begin
			if (c_we) begin
				cvld_q[pos_q] <= 1'b1;
			end
			if (p_we) begin
				pvld_q[pos_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						last_q <= in_data.last_term;
						if (cnt_q < CW'(MAX_TERMS)) begin
							state_q <= ST_RIN_W;
						end else if (in_data.last_term) begin
							state_q <= ST_EM_ST;
						end
					end
				end
				ST_RIN_W: begin
					if (mm_rsp.done) begin
						n_q     <= cnt_q;
						cnt_q   <= cnt_q + CW'(1);
						i_q     <= '0;
						d_q     <= '0;
						state_q <= ST_DSC_RD;
					end
				end
				ST_DSC_RD: begin
					state_q <= ST_DSC_DAT;
				end
				ST_DSC_DAT: begin
					state_q <= ST_DSC_W;
				end
				ST_DSC_W: begin
					if (mm_rsp.done) begin
						d_q <= d_nxt;
						if (CW'(i_q) == lim) begin
							state_q <= ST_CHK;
						end else begin
							i_q     <= i_q + PAW'(1);
							state_q <= ST_DSC_RD;
						end
					end
				end
				ST_CHK: begin
					chg_q <= ({1'b0, len_q, 1'b0} <= {2'b00, n_q});
					if (d_q == '0) begin
						shift_q <= shift_q + CW'(1);
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_INV_RB;
					end
				end
				ST_INV_RB: begin
					if (mm_rsp.done) begin
						base_q  <= mm_rsp.value;
						inv_q   <= W'(1);
						j_q     <= SW'(W - 1);
						state_q <= ST_INV_SQ;
					end
				end
				ST_INV_SQ: begin
					state_q <= ST_INV_SQW;
				end
				ST_INV_SQW: begin
					if (mm_rsp.done) begin
						inv_q <= mm_rsp.value;
						if (expo[j_q]) begin
							state_q <= ST_INV_MUW;
						end else if (j_q == '0) begin
							state_q <= ST_FAC;
						end else begin
							j_q     <= j_q - SW'(1);
							state_q <= ST_INV_SQ;
						end
					end
				end
				ST_INV_MUW: begin
					if (mm_rsp.done) begin
						inv_q <= mm_rsp.value;
						if (j_q == '0) begin
							state_q <= ST_FAC;
						end else begin
							j_q     <= j_q - SW'(1);
							state_q <= ST_INV_SQ;
						end
					end
				end
				ST_FAC: begin
					state_q <= ST_FAC_W;
				end
				ST_FAC_W: begin
					if (mm_rsp.done) begin
						f_q     <= mm_rsp.value;
						pos_q   <= PAW'(POLY_DEPTH - 1);
						state_q <= ST_UPD_RD;
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_DAT;
				end
				ST_UPD_DAT: begin
					cold_q <= cval;
					if (pos_q >= PAW'(shift_q)) begin
						state_q <= ST_UPD_M1;
					end else begin
						state_q <= ST_UPD_NX;
					end
				end
				ST_UPD_M1: begin
					if (mm_rsp.done) begin
						sub_q   <= mm_rsp.value;
						state_q <= ST_UPD_RC;
					end
				end
				ST_UPD_RC: begin
					if (cold_q >= pe) begin
						state_q <= ST_UPD_M2;
					end else begin
						cr_q    <= cold_q;
						state_q <= ST_UPD_WR;
					end
				end
				ST_UPD_M2: begin
					if (mm_rsp.done) begin
						cr_q    <= mm_rsp.value;
						state_q <= ST_UPD_WR;
					end
				end
				ST_UPD_WR: begin
					state_q <= ST_UPD_NX;
				end
				ST_UPD_NX: begin
					if (pos_q == '0) begin
						state_q <= ST_UPD_END;
					end else begin
						pos_q   <= pos_q - PAW'(1);
						state_q <= ST_UPD_RD;
					end
				end
				ST_UPD_END: begin
					if (chg_q) begin
						len_q   <= n_q + CW'(1) - len_q;
						ldisc_q <= d_q;
						shift_q <= CW'(1);
					end else begin
						shift_q <= shift_q + CW'(1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= last_q ? ST_EM_ST : ST_IDLE;
				end
				ST_EM_ST: begin
					if (len_q == '0) begin
						if (!ovld_q) begin
							state_q <= ST_CLR;
						end
					end else begin
						k_q     <= PAW'(1);
						state_q <= ST_EM_RD;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_DAT;
				end
				ST_EM_DAT: begin
					state_q <= ST_EM_W;
				end
				ST_EM_W: begin
					if (mm_rsp.done) begin
						coef_q  <= (mm_rsp.value == '0) ? '0 : pe - mm_rsp.value;
						state_q <= ST_EM_OUT;
					end
				end
				ST_EM_OUT: begin
					if (!ovld_q) begin
						if (CW'(k_q) == len_q) begin
							state_q <= ST_CLR;
						end else begin
							k_q     <= k_q + PAW'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				ST_CLR: begin
					cvld_q  <= '0;
					pvld_q  <= '0;
					cnt_q   <= '0;
					len_q   <= '0;
					shift_q <= CW'(1);
					ldisc_q <= W'(1);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			out_q  <= '0;
		end else begin
			if (out_load) begin
				ovld_q <= 1'b1;
				if (len_q == '0) begin
					out_q.coefficient <= '0;
					out_q.coef_index  <= '0;
					out_q.rec_length  <= '0;
					out_q.run_end     <= 1'b1;
				end else begin
					out_q.coefficient <= coef_q;
					out_q.coef_index  <= CW'(k_q);
					out_q.rec_length  <= len_q;
					out_q.run_end     <= (CW'(k_q) == len_q);
				end
			end else if (ovld_q && !out_stall) begin
				ovld_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ----- src/bmr_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module bmr_checker import bmr_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_stall,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire bmr_out_t out_data
);

	// a stalled result holds
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

	// no new term while a run is still being sent
	`ASSERT_CLK(a_run_busy, out_valid && !out_data.run_end |-> in_stall, "term taken during a run")

	// run end marks the coefficient of the top index
	`ASSERT_CLK(a_run_end, out_valid |-> (out_data.run_end == (out_data.coef_index == out_data.rec_length)), "run end misplaced")

	// zero length gives the single empty item
	`ASSERT_CLK(a_zero_len, out_valid && out_data.rec_length == 0 |-> out_data.coefficient == 0 && out_data.coef_index == 0, "bad zero length item")

	// nothing leaves during reset
	`ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "result during reset")

endmodule

bind berlekamp_massey_recurrence_unit bmr_checker u_bmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
